FILE: src/ece_pkg.sv
// Package for the easing curve evaluator: fixed-point constants, widths,
// register indexes and easing modes. No dependencies.
package ece_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int NEWTON_STEPS_DEF = 8;
	localparam int BISECT_STEPS_DEF = 32;

	localparam int PROG_W = 18;
	localparam int OUT_W  = 20;
	localparam int MODE_W = 3;
	localparam int CX_W   = 17;
	localparam int CY_W   = 19;

	// Register indexes
	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_X1   = 3'd1;
	localparam logic [2:0] REG_X2   = 3'd2;
	localparam logic [2:0] REG_Y1   = 3'd3;
	localparam logic [2:0] REG_Y2   = 3'd4;

	// Easing modes
	localparam logic [2:0] MODE_LINEAR = 3'd0;
	localparam logic [2:0] MODE_SMOOTH = 3'd1;
	localparam logic [2:0] MODE_CUBOUT = 3'd2;
	localparam logic [2:0] MODE_BACK   = 3'd3;
	localparam logic [2:0] MODE_BEZIER = 3'd4;

	// Multiplier operand/product widths
	localparam int OP_W   = 32;
	localparam int PROD_W = 64;

endpackage

FILE: src/ece_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, signed operands,
// quotient truncated toward zero. Depends on no other file.
module ece_div #(
	parameter int W = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] dividend,
	input  logic signed [W-1:0] divisor,
	output logic                done,
	output logic signed [W-1:0] quotient
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, neg_q, done_q;
	logic [W:0]    trial;

	assign trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[W-1] ? W'(-dividend) : dividend;
			den_q <= divisor[W-1] ? W'(-divisor) : divisor;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-2:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? W'(-$signed(quo_q)) : $signed(quo_q);
endmodule

FILE: src/easing_curve_evaluator_core.sv
// Easing curve evaluator top level: APB register file, input/output
// handshakes and a microcoded sequencer around one shared multiplier.
// Depends on ece_pkg and ece_div.
//
// One progress item is clamped to [0,1] and mapped by the selected easing
// curve. All products go through a single registered multiplier that rounds
// to nearest (ties up); a sequencer feeds it one product per cycle in its
// multiply states. Custom bezier runs up to NEWTON_STEPS Newton steps, each a
// curve evaluation, a check, a slope and a division in the serial W-bit
// divider (W = FRAC_BITS+32), then up to BISECT_STEPS bisection steps and a
// final curve evaluation; its run time is set by the shared multiplier and
// the serial divider. The block accepts one item at a time; the result sits
// in an output register, and a new item is taken once the previous result
// has been taken.
module easing_curve_evaluator_core #(
	parameter int FRAC_BITS    = ece_pkg::FRAC_BITS_DEF,
	parameter int NEWTON_STEPS = ece_pkg::NEWTON_STEPS_DEF,
	parameter int BISECT_STEPS = ece_pkg::BISECT_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [4:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [ece_pkg::PROG_W-1:0] progress,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ece_pkg::OUT_W-1:0]  eased_value
);
	// Internal datapath width: values stay well under this.
	localparam int DW  = FRAC_BITS + 12;
	localparam int MW  = 2 * DW;
	localparam int QW  = FRAC_BITS + 32;
	localparam logic signed [DW-1:0] ONE = DW'(1) <<< FRAC_BITS;
	localparam longint C1_L = ((longint'(170158) << FRAC_BITS) + 50000) / 100000;
	localparam logic signed [DW-1:0] C1 = DW'(C1_L);
	localparam logic signed [DW-1:0] C3 = DW'(C1_L + (longint'(1) << FRAC_BITS));
	localparam int NCW = $clog2(NEWTON_STEPS + 1);
	localparam int BCW = $clog2(BISECT_STEPS + 1);

	// Sequencer states
	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_POLY   = 5'd1;
	localparam logic [4:0] ST_CURVE  = 5'd2;
	localparam logic [4:0] ST_NCHK   = 5'd3;
	localparam logic [4:0] ST_SLOPE  = 5'd4;
	localparam logic [4:0] ST_DIVST  = 5'd5;
	localparam logic [4:0] ST_DIVW   = 5'd6;
	localparam logic [4:0] ST_BCHK   = 5'd7;
	localparam logic [4:0] ST_FIN    = 5'd8;
	localparam logic [4:0] ST_OUT    = 5'd9;

	// Curve evaluation purpose
	localparam logic [1:0] CV_NEWTON = 2'd0;
	localparam logic [1:0] CV_BISECT = 2'd1;
	localparam logic [1:0] CV_FINAL  = 2'd2;

	// ---------------- Registers ----------------
	logic [ece_pkg::MODE_W-1:0]      mode_q;
	logic [ece_pkg::CX_W-1:0]        x1_q, x2_q;
	logic signed [ece_pkg::CY_W-1:0] y1_q, y2_q;
	logic                            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			x1_q   <= '0;
			x2_q   <= ece_pkg::CX_W'(65536);
			y1_q   <= '0;
			y2_q   <= ece_pkg::CY_W'(65536);
		end else if (wr_en) begin
			case (paddr[4:2])
				ece_pkg::REG_MODE: mode_q <= pwdata[ece_pkg::MODE_W-1:0];
				ece_pkg::REG_X1:   x1_q   <= pwdata[ece_pkg::CX_W-1:0];
				ece_pkg::REG_X2:   x2_q   <= pwdata[ece_pkg::CX_W-1:0];
				ece_pkg::REG_Y1:   y1_q   <= pwdata[ece_pkg::CY_W-1:0];
				ece_pkg::REG_Y2:   y2_q   <= pwdata[ece_pkg::CY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			ece_pkg::REG_MODE: prdata = 32'(mode_q);
			ece_pkg::REG_X1:   prdata = 32'(x1_q);
			ece_pkg::REG_X2:   prdata = 32'(x2_q);
			ece_pkg::REG_Y1:   prdata = 32'(unsigned'(y1_q));
			ece_pkg::REG_Y2:   prdata = 32'(unsigned'(y2_q));
			default:           prdata = '0;
		endcase
	end

	// ---------------- Shared multiplier ----------------
	// Operands chosen by the sequencer; product rounded and registered.
	logic signed [DW-1:0] ma, mb, mr_q;
	logic signed [MW-1:0] prod;

	assign prod = (MW'(ma) * MW'(mb)) + (MW'(1) <<< (FRAC_BITS - 1));
	always_ff @(posedge clk) mr_q <= DW'(prod >>> FRAC_BITS);

	// ---------------- Sequencer ----------------
	logic [4:0]           st_q;
	logic [3:0]           ph_q;
	logic [1:0]           cv_q;
	logic signed [DW-1:0] t_q, s_q, lo_q, hi_q, p1_q, p2_q;
	logic signed [DW-1:0] a_q, b_q, c_q, acc_q;
	logic [NCW-1:0]       ncnt_q;
	logic [BCW-1:0]       bcnt_q;
	logic signed [ece_pkg::OUT_W-1:0] res_q;
	logic                 ovld_q;
	logic signed [DW-1:0] u_s, t_in, snew;
	logic signed [QW-1:0] quo;
	logic                 div_start, div_done;
	logic signed [QW-1:0] s_nw;

	assign u_s = ONE - s_q;
	assign t_in = progress[ece_pkg::PROG_W-1] ? '0 :
		(DW'(progress) > ONE ? ONE : DW'(progress));

	// Operand selection per state/phase
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			ST_POLY: begin
				case (mode_q)
					ece_pkg::MODE_SMOOTH: begin
						if (ph_q == 4'd0) begin ma = t_q; mb = t_q; end
						else begin ma = mr_q; mb = DW'(3 * ONE - 2 * t_q); end
					end
					ece_pkg::MODE_CUBOUT: begin
						if (ph_q == 4'd0) begin ma = ONE - t_q; mb = ONE - t_q; end
						else begin ma = mr_q; mb = ONE - t_q; end
					end
					default: begin
						// back out: u = t-1; u2, u3, c3*u3, c1*u2
						case (ph_q)
							4'd0:    begin ma = t_q - ONE; mb = t_q - ONE; end
							4'd1:    begin ma = mr_q; mb = t_q - ONE; end
							4'd2:    begin ma = mr_q; mb = C3; end
							default: begin ma = a_q; mb = C1; end
						endcase
					end
				endcase
			end
			ST_CURVE: begin
				case (ph_q)
					4'd0:    begin ma = u_s; mb = u_s; end   // uu
					4'd1:    begin ma = s_q; mb = s_q; end   // ss
					4'd2:    begin ma = a_q; mb = s_q; end   // uu*s
					4'd3:    begin ma = b_q; mb = u_s; end   // ss*u
					4'd4:    begin ma = b_q; mb = s_q; end   // ss*s
					4'd5:    begin ma = a_q; mb = p1_q; end
					default: begin ma = c_q; mb = p2_q; end
				endcase
			end
			ST_SLOPE: begin
				// Each of uu, us and ss is scaled from mr_q in the cycle after it is formed.
				case (ph_q)
					4'd0:    begin ma = u_s; mb = u_s; end
					4'd1:    begin ma = mr_q; mb = p1_q; end
					4'd2:    begin ma = u_s; mb = s_q; end
					4'd3:    begin ma = mr_q; mb = p2_q - p1_q; end
					4'd4:    begin ma = s_q; mb = s_q; end
					default: begin ma = mr_q; mb = ONE - p2_q; end
				endcase
			end
			default: ;
		endcase
	end

	assign div_start = (st_q == ST_DIVST);
	ece_div #(.W(QW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (QW'(acc_q) <<< FRAC_BITS),
		.divisor  (QW'(c_q)),
		.done     (div_done),
		.quotient (quo)
	);
	assign s_nw = QW'(s_q) - quo;
	assign snew = s_nw < 0 ? '0 : (s_nw > QW'(ONE) ? ONE : DW'(s_nw));

	// Saturate and hold the result
	function automatic logic signed [ece_pkg::OUT_W-1:0] sat(input logic signed [DW-1:0] v);
		if (v > DW'(524287))       sat = 20'sd524287;
		else if (v < -DW'(524288)) sat = -20'sd524288;
		else                       sat = ece_pkg::OUT_W'(v);
	endfunction

	assign in_ready    = (st_q == ST_IDLE) && !ovld_q;
	assign out_valid   = ovld_q;
	assign eased_value = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			ph_q   <= '0;
			ovld_q <= 1'b0;
			cv_q   <= CV_NEWTON;
			ncnt_q <= '0;
			bcnt_q <= '0;
		end else begin
			if (ovld_q && out_ready) ovld_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						ph_q <= '0;
						if (mode_q == ece_pkg::MODE_SMOOTH || mode_q == ece_pkg::MODE_CUBOUT
							|| mode_q == ece_pkg::MODE_BACK)
							st_q <= ST_POLY;
						else if (mode_q == ece_pkg::MODE_BEZIER) begin
							st_q   <= ST_CURVE;
							cv_q   <= CV_NEWTON;
							ncnt_q <= '0;
						end else
							st_q <= ST_OUT;
					end
				end
				ST_POLY: begin
					ph_q <= ph_q + 1'b1;
					if ((mode_q != ece_pkg::MODE_BACK && ph_q == 4'd2)
						|| ph_q == 4'd4) st_q <= ST_OUT;
				end
				ST_CURVE: begin
					if (ph_q == 4'd7) begin
						ph_q <= '0;
						case (cv_q)
							CV_NEWTON: st_q <= ST_NCHK;
							CV_BISECT: st_q <= ST_BCHK;
							default:   st_q <= ST_OUT;
						endcase
					end else
						ph_q <= ph_q + 1'b1;
				end
				ST_NCHK: begin
					if (acc_q == t_q) begin
						st_q <= ST_CURVE;
						cv_q <= CV_FINAL;
					end else
						st_q <= ST_SLOPE;
				end
				ST_SLOPE: begin
					if (ph_q == 4'd6) begin
						ph_q <= '0;
						st_q <= ST_DIVST;
					end else
						ph_q <= ph_q + 1'b1;
				end
				ST_DIVST: begin
					if (c_q == '0) begin
						st_q   <= ST_CURVE;
						cv_q   <= CV_BISECT;
						bcnt_q <= '0;
					end else
						st_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						st_q <= ST_CURVE;
						if (ncnt_q == NCW'(NEWTON_STEPS - 1)) begin
							cv_q   <= CV_BISECT;
							bcnt_q <= '0;
						end else
							ncnt_q <= ncnt_q + 1'b1;
					end
				end
				ST_BCHK: begin
					st_q <= ST_CURVE;
					if (acc_q == t_q || bcnt_q == BCW'(BISECT_STEPS - 1))
						cv_q <= CV_FINAL;
					else
						bcnt_q <= bcnt_q + 1'b1;
				end
				ST_FIN: st_q <= ST_OUT;
				ST_OUT: begin
					st_q   <= ST_IDLE;
					ovld_q <= 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				t_q   <= t_in;
				s_q   <= t_in;
				lo_q  <= '0;
				hi_q  <= ONE;
				acc_q <= t_in;
				p1_q  <= (DW'(x1_q) > ONE) ? ONE : DW'(x1_q);
				p2_q  <= (DW'(x2_q) > ONE) ? ONE : DW'(x2_q);
			end
			ST_POLY: begin
				if (mode_q == ece_pkg::MODE_SMOOTH) begin
					if (ph_q == 4'd2) acc_q <= mr_q;
				end else if (mode_q == ece_pkg::MODE_CUBOUT) begin
					if (ph_q == 4'd2) acc_q <= ONE - mr_q;
				end else begin
					case (ph_q)
						4'd1: a_q <= mr_q;          // u2
						4'd3: acc_q <= ONE + mr_q;  // c3*u3
						4'd4: acc_q <= acc_q + mr_q; // c1*u2
						default: ;
					endcase
				end
			end
			ST_CURVE: begin
				case (ph_q)
					4'd0: if (cv_q == CV_FINAL) begin
						p1_q <= DW'(y1_q);
						p2_q <= DW'(y2_q);
					end
					4'd1: a_q <= mr_q;               // uu
					4'd2: b_q <= mr_q;               // ss
					4'd3: a_q <= mr_q;               // uu*s
					4'd4: c_q <= mr_q;               // ss*u
					4'd5: acc_q <= mr_q;             // ss*s
					4'd6: acc_q <= DW'(acc_q + 3 * mr_q);
					default: acc_q <= DW'(acc_q + 3 * mr_q);
				endcase
			end
			ST_NCHK: acc_q <= acc_q - t_q;
			ST_SLOPE: begin
				case (ph_q)
					4'd2: c_q <= DW'(3 * mr_q);
					4'd4: c_q <= DW'(c_q + 6 * mr_q);
					4'd6: c_q <= DW'(c_q + 3 * mr_q);
					default: ;
				endcase
			end
			ST_DIVST: if (c_q == '0) s_q <= t_q;
			ST_DIVW: begin
				if (div_done)
					s_q <= (ncnt_q == NCW'(NEWTON_STEPS - 1)) ? t_q : snew;
			end
			ST_BCHK: begin
				if (acc_q != t_q && bcnt_q != BCW'(BISECT_STEPS - 1)) begin
					if (acc_q < t_q) begin
						lo_q <= s_q;
						s_q  <= (s_q + hi_q) >>> 1;
					end else begin
						hi_q <= s_q;
						s_q  <= (lo_q + s_q) >>> 1;
					end
				end else if (acc_q != t_q) begin
					if (acc_q < t_q) s_q <= (s_q + hi_q) >>> 1;
					else             s_q <= (lo_q + s_q) >>> 1;
				end
			end
			ST_OUT: res_q <= sat(acc_q);
			default: ;
		endcase
	end
endmodule

FILE: src/ece_checker.sv
// Port-level checker for the easing curve evaluator, bound to the top level.
// Depends on ece_pkg.
module ece_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [ece_pkg::OUT_W-1:0]  eased_value
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("ready right after accept");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(eased_value)))
		else $error("result dropped or changed");
	a_no_out_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> !out_valid) else $error("result repeated");
endmodule

bind easing_curve_evaluator_core ece_checker u_ece_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.eased_value (eased_value)
);
